FILE: rtl/core/aes128_pkg.sv
// Package: AES-128 types, S-box and round primitives.
package aes128_pkg;

  localparam int NumRounds = 10;
  localparam int KeyWidth  = 64;
  localparam int CfgIdxWidth = 1;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_t;

  typedef logic [127:0] block_t;

  typedef struct packed {
    logic   valid;
    block_t state;
    block_t rkey;
  } stage_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
      8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
      8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
      8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
      8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
      8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
      8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
      8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
      8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
      8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
      8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
      8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
      8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
      8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
      8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
      8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
      8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
      8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
      8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
      8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
      8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
      8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
      8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
      8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
      8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
      8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
      8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
      8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
      8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
      8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
      8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
      8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
      8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
      8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
      8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
      8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
      8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
      8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
      8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
      8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
      8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
      8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
      8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
      8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
      8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
      8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
      8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
      8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
      8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
      8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
      8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
      8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
      8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
      8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
      8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
      8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
      8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
      8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
      8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
      8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
      8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
      8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
      8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
      8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] round);
    logic [7:0] r;
    case (round)
      4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
      4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
      4'd9: r = 8'h1b; 4'd10: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a block is bits 127-8i .. 120-8i.
  function automatic logic [7:0] get_byte(input block_t b, input int i);
    return b[127-8*i -: 8];
  endfunction

  function automatic block_t next_round_key(input block_t k, input logic [3:0] round);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rcon(round), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic block_t enc_round(input block_t b, input block_t rk, input logic mix);
    block_t t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = sbox(get_byte(b, 4*((c+r)%4)+r));
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[127-32*c -: 8];
        a1 = t[119-32*c -: 8];
        a2 = t[111-32*c -: 8];
        a3 = t[103-32*c -: 8];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[127-32*c -: 8] = a0 ^ all ^ gf_dbl(a0 ^ a1);
        t[119-32*c -: 8] = a1 ^ all ^ gf_dbl(a1 ^ a2);
        t[111-32*c -: 8] = a2 ^ all ^ gf_dbl(a2 ^ a3);
        t[103-32*c -: 8] = a3 ^ all ^ gf_dbl(a3 ^ a0);
      end
    end
    return t ^ rk;
  endfunction

endpackage

FILE: rtl/core/aes128_round_cell.sv
// One round cell: applies a cipher round and steps the round key along with the block.
module aes128_round_cell #(
  parameter logic [3:0] Round = 4'd1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  aes128_pkg::stage_t      prev,
  output aes128_pkg::stage_t      cur
);
  import aes128_pkg::*;

  block_t rk_next;

  always_comb begin
    rk_next = next_round_key(prev.rkey, Round);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (en) begin
      cur.valid <= prev.valid;
    end
    if (en) begin
      cur.rkey  <= rk_next;
      cur.state <= enc_round(prev.state, rk_next, Round != 4'(NumRounds));
    end
  end

endmodule

FILE: rtl/core/aes128_block_encrypt_unit.sv
// Top level: key registers, initial key add, chain of ten round cells; the last cell drives the output.
// Pipeline: input stage plus 10 round cell registers between input transaction and output valid.
// Throughput: one block per clock; the whole chain advances together and stalls only
// while the final cell holds a result that the output side has not taken.
// Reset (rst, synchronous): clears all valid flags and both key registers to zero.
module aes128_block_encrypt_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [aes128_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  logic [aes128_pkg::KeyWidth-1:0]     cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [127:0]                        s_axis_tdata,  // plaintext_low in [127:64], plaintext_high in [63:0]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [127:0]                        m_axis_tdata   // ciphertext_low in [127:64], ciphertext_high in [63:0]
);
  import aes128_pkg::*;

  logic [KeyWidth-1:0] key_high, key_low;
  stage_t chain [NumRounds+1];
  logic   adv;

  assign adv = !chain[NumRounds].valid || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // plaintext_high in tdata[63:0]: byte order puts it in the block's upper half.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (adv) begin
      chain[0].valid <= s_axis_tvalid;
    end
    if (adv) begin
      chain[0].rkey  <= {key_high, key_low};
      chain[0].state <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^ {key_high, key_low};
    end
  end

  for (genvar g = 1; g <= NumRounds; g++) begin : g_round
    aes128_round_cell #(.Round(4'(g))) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .prev (chain[g-1]),
      .cur  (chain[g])
    );
  end

  assign m_axis_tvalid = chain[NumRounds].valid;
  assign m_axis_tdata  = {chain[NumRounds].state[63:0], chain[NumRounds].state[127:64]};

endmodule

FILE: rtl/core/aes128_sva.sv
// Port checker for the AES-128 encrypt unit, bound to the top level.
module aes128_sva (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("tvalid dropped");
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("tdata moved");
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready) else $error("stall with empty output");
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("accept while stalled");
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid) else $error("valid after reset");
endmodule

bind aes128_block_encrypt_unit aes128_sva u_aes128_sva (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: bench/tb.sv
// Testbench for aes128_block_encrypt_unit: streams plaintext blocks and checks ciphertext.
module tb;
  import aes128_pkg::*;

  localparam int IdleLimit = 5000;
  localparam int DrainCycles = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index = REG_KEY_HIGH;
  logic [KeyWidth-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = '0;  // plaintext_low in [127:64], plaintext_high in [63:0]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;       // ciphertext_low in [127:64], ciphertext_high in [63:0]

  aes128_block_encrypt_unit u_top (.*);

  logic [7:0] sbox_lut [256];
  logic [63:0] key_hi_shadow = '0;
  logic [63:0] key_lo_shadow = '0;
  logic [127:0] cipher_expected [$];  // {high, low}
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holdoff_req = 0;
  int errors = 0;
  int blocks_sent = 0;
  int blocks_checked = 0;
  int key_writes = 0;
  int quiet_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = xtime(a);
    end
    return p;
  endfunction

  // S-box from the field inverse plus the affine map.
  task automatic build_sbox();
    logic [7:0] inv, s;
    for (int a = 0; a < 256; a++) begin
      inv = '0;
      for (int b = 1; b < 256; b++)
        if (a != 0 && gf_mul(8'(a), 8'(b)) == 8'h01) inv = 8'(b);
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox_lut[a] = s;
    end
  endtask

  function automatic logic [127:0] aes_encrypt(input logic [127:0] key, input logic [127:0] pt);
    logic [7:0] w [44][4];
    logic [7:0] st [16];
    logic [7:0] t [16];
    logic [7:0] tmp [4];
    logic [7:0] first, rc, a0, a1, a2, a3, all;
    logic [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) w[i/4][i%4] = key[127-8*i -: 8];
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) tmp[j] = w[i-1][j];
      if (i % 4 == 0) begin
        first = tmp[0];
        tmp[0] = sbox_lut[tmp[1]] ^ rc;
        tmp[1] = sbox_lut[tmp[2]];
        tmp[2] = sbox_lut[tmp[3]];
        tmp[3] = sbox_lut[first];
        rc = xtime(rc);
      end
      for (int j = 0; j < 4; j++) w[i][j] = w[i-4][j] ^ tmp[j];
    end
    for (int i = 0; i < 16; i++) st[i] = pt[127-8*i -: 8] ^ w[i/4][i%4];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[4*c+r] = sbox_lut[st[4*((c+r)%4)+r]];
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
          t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
          t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
          t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
        end
      end
      for (int k = 0; k < 16; k++) st[k] = t[k] ^ w[4*rnd + k/4][k%4];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0: v = '0;
      1: v = '1;
      2: v = 64'h1 << $urandom_range(0, 63);
      3: v = ~(64'h1 << $urandom_range(0, 63));
      default: ;
    endcase
    return v;
  endfunction

  task automatic wait_drained();
    while (cipher_expected.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
    s_axis_tvalid = 1'b0;
    wait_drained();
    cfg_we = 1'b1;
    cfg_index = REG_KEY_HIGH;
    cfg_data = hi;
    @(negedge clk);
    cfg_index = REG_KEY_LOW;
    cfg_data = lo;
    @(negedge clk);
    cfg_we = 1'b0;
    key_hi_shadow = hi;
    key_lo_shadow = lo;
    key_writes += 2;
  endtask

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {lo, hi};
    do @(posedge clk); while (!s_axis_tready);
    cipher_expected.push_back(aes_encrypt({key_hi_shadow, key_lo_shadow}, {hi, lo}));
    blocks_sent++;
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic stop_sending();
    s_axis_tvalid = 1'b0;
  endtask

  always @(negedge clk) begin
    if (holdoff_req > 0) begin
      m_axis_tready = 1'b0;
      holdoff_req = holdoff_req - 1;
    end else begin
      m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    logic [127:0] exp_blk;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (cipher_expected.size() == 0) begin
        $display("%0t: unexpected ciphertext %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp_blk = cipher_expected.pop_front();
        blocks_checked++;
        if (m_axis_tdata[63:0] !== exp_blk[127:64]) begin
          $display("%0t: ciphertext_high expected %h actual %h", $time, exp_blk[127:64],
                   m_axis_tdata[63:0]);
          errors++;
        end
        if (m_axis_tdata[127:64] !== exp_blk[63:0]) begin
          $display("%0t: ciphertext_low expected %h actual %h", $time, exp_blk[63:0],
                   m_axis_tdata[127:64]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("%0t: timeout, %0d transactions outstanding", $time, cipher_expected.size());
      $display("aes128_block_encrypt_unit test failed");
      $finish;
    end
  end

  task automatic test_zero_key();
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h8000000000000000, 64'h0);
    send_block(64'h0, 64'h1);
    stop_sending();
  endtask

  task automatic test_known_vector();
    write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
    send_block('0, '0);
    send_block('1, '1);
    stop_sending();
  endtask

  task automatic test_key_extremes();
    write_key('1, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    write_key('1, '0);
    send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    send_block('0, '1);
    write_key('0, '1);
    send_block('1, '0);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
    stop_sending();
  endtask

  task automatic test_random_stream(input int n, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      if (i % 120 == 0) begin
        stop_sending();
        write_key(rand64(), rand64());
      end
      send_block(rand64(), rand64());
    end
    stop_sending();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_key(rand64(), rand64());
    holdoff_req = 80;
    for (int i = 0; i < 40; i++) send_block(rand64(), rand64());
    stop_sending();
    // sender pauses until the pipeline is empty
    while (cipher_expected.size() != 0) @(negedge clk);
    for (int i = 0; i < 20; i++) send_block(rand64(), rand64());
    stop_sending();
  endtask

  initial begin
    build_sbox();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    test_zero_key();
    test_known_vector();
    test_key_extremes();
    test_random_stream(460, 13, 48);
    test_random_stream(460, 48, 13);
    test_random_stream(460, 0, 0);
    test_backpressure();
    wait_drained();
    $display("Encrypted %0d blocks, checked %0d, with %0d key register writes", blocks_sent,
             blocks_checked, key_writes);
    $display("covered key extremes, known vectors, random keys, idling and a long stall");
    if (errors == 0 && cipher_expected.size() == 0) begin
      $display("aes128_block_encrypt_unit test passed");
    end else begin
      $display("aes128_block_encrypt_unit test failed");
    end
    $finish;
  end

endmodule
